[design/interval_task_dispatcher_assert.svh]
// Assertion macros shared by the dispatcher checker.
`ifndef INTERVAL_TASK_DISPATCHER_ASSERT_SVH
`define INTERVAL_TASK_DISPATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/itd_pkg.sv]
// Types and constants of the interval task dispatcher.
`timescale 1ns / 1ps

package itd_pkg;

  // Fixed field widths of the request and result.
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned TASK_IDX_W = 4;
  localparam int unsigned IVAL_W     = 32;
  localparam int unsigned CTIME_W    = 32;

  // Number of entries that a request can address.
  localparam int unsigned TASK_SLOTS = 1 << TASK_IDX_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE   = 3'd0,
    ACT_SET_IVAL = 3'd1,
    ACT_SET_ACT  = 3'd2,
    ACT_STAMP    = 3'd3,
    ACT_SCAN     = 3'd4
  } itd_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } itd_state_t;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [TASK_IDX_W-1:0] task_index;
    logic [IVAL_W-1:0]     interval;
    logic                  has_handler;
    logic                  active;
    logic [CTIME_W-1:0]    current_time;
  } itd_in_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] fired_task;
    logic                  last_in_scan;
  } itd_out_t;

  // Write strobes and data broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                  create;
    logic                  set_ival;
    logic                  set_act;
    logic                  stamp;
    logic [TASK_IDX_W-1:0] task_index;
    logic [IVAL_W-1:0]     interval;
    logic                  has_handler;
    logic                  active;
  } itd_cell_ctl_t;

endpackage

[design/itd_cell.sv]
// One task entry of the dispatcher chain with its scan token stage.
`timescale 1ns / 1ps

module itd_cell #(
  parameter int unsigned CELL_IDX  = 0,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itd_pkg::itd_cell_ctl_t ctl,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [TIME_BITS-1:0]  scan_time,
  input  logic                  tok_in,
  output logic                  tok_out,
  output logic                  fire
);
  import itd_pkg::*;

  localparam int unsigned CMP_W       = (TIME_BITS > IVAL_W) ? TIME_BITS : IVAL_W;
  localparam bit          ADDRESSABLE = (CELL_IDX < TASK_SLOTS);

  logic                 tok_r;
  logic                 en_r, en_nxt;
  logic                 pres_r, pres_nxt;
  logic [TIME_BITS-1:0] last_fire_r, last_fire_nxt;
  logic [IVAL_W-1:0]    interval_r;
  logic                 sel;
  logic [TIME_BITS-1:0] elapsed;
  logic                 due;

  // Decode whether the request addresses this entry
  assign sel = ADDRESSABLE && (ctl.task_index == TASK_IDX_W'(CELL_IDX));

  // Wrapped elapsed time against the interval
  assign elapsed = scan_time - last_fire_r;
  assign due     = CMP_W'(elapsed) >= CMP_W'(interval_r);

  assign fire    = tok_r && en_r && pres_r && due;
  assign tok_out = tok_r;

  // Work out the flag and timestamp updates
  always_comb begin
    en_nxt        = en_r;
    pres_nxt      = pres_r;
    last_fire_nxt = last_fire_r;
    if (sel && ctl.create) begin
      en_nxt   = ctl.active;
      pres_nxt = ctl.has_handler;
    end
    if (sel && ctl.set_act) begin
      en_nxt = ctl.active;
    end
    if (ctl.stamp) begin
      last_fire_nxt = now;
    end else if (fire) begin
      last_fire_nxt = scan_time;
    end
  end

  // Hold the token, flags and timestamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r       <= 1'b0;
      en_r        <= 1'b0;
      pres_r      <= 1'b0;
      last_fire_r <= '0;
    end else begin
      tok_r       <= tok_in;
      en_r        <= en_nxt;
      pres_r      <= pres_nxt;
      last_fire_r <= last_fire_nxt;
    end
  end

  // Interval is only read once the entry has been created
  always_ff @(posedge clk) begin
    if (sel && (ctl.create || ctl.set_ival)) begin
      interval_r <= ctl.interval;
    end
  end

endmodule

[design/itd_ctrl.sv]
// Request decoder and scan sequencer of the dispatcher.
`timescale 1ns / 1ps

module itd_ctrl #(
  parameter int unsigned TASK_COUNT = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  itd_pkg::itd_in_t       in_item,
  input  logic                   any_fire,
  output logic                   busy,
  output logic                   launch,
  output itd_pkg::itd_cell_ctl_t ctl,
  output logic [TIME_BITS-1:0]   now,
  output logic [TIME_BITS-1:0]   scan_time,
  output logic                   out_strobe,
  output itd_pkg::itd_out_t      out_item
);
  import itd_pkg::*;

  localparam int unsigned POS_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(TASK_COUNT - 1);

  itd_state_t            state_r, state_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [TIME_BITS-1:0]  scan_time_r, scan_time_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [TASK_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  itd_out_t              out_item_r, out_item_nxt;
  logic                  accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign now       = TIME_BITS'(in_item.current_time);
  assign scan_time = scan_time_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Decode the accepted request into cell write strobes
  always_comb begin
    ctl.create      = 1'b0;
    ctl.set_ival    = 1'b0;
    ctl.set_act     = 1'b0;
    ctl.stamp       = 1'b0;
    ctl.task_index  = in_item.task_index;
    ctl.interval    = in_item.interval;
    ctl.has_handler = in_item.has_handler;
    ctl.active      = in_item.active;
    launch          = 1'b0;
    unique case (in_item.action)
      ACT_CREATE:   ctl.create   = accept;
      ACT_SET_IVAL: ctl.set_ival = accept;
      ACT_SET_ACT:  ctl.set_act  = accept;
      ACT_STAMP:    ctl.stamp    = accept;
      ACT_SCAN:     launch       = accept;
      default:      launch       = 1'b0;
    endcase
  end

  // Walk the token, hold one fire back so the last one can be flagged
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    scan_time_nxt  = scan_time_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (launch) begin
          state_nxt     = ST_SCAN;
          pos_nxt       = '0;
          scan_time_nxt = now;
          pend_v_nxt    = 1'b0;
        end
      end
      ST_SCAN: begin
        if (any_fire) begin
          if (pend_v_r) begin
            out_strobe_nxt            = 1'b1;
            out_item_nxt.fired_task   = pend_idx_r;
            out_item_nxt.last_in_scan = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = TASK_IDX_W'(pos_r);
        end
        if (pos_r == POS_LAST) begin
          state_nxt = ST_FLUSH;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          out_strobe_nxt            = 1'b1;
          out_item_nxt.fired_task   = pend_idx_r;
          out_item_nxt.last_in_scan = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_time_r <= scan_time_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

[design/interval_task_dispatcher.sv]
// Top level of the interval task dispatcher: sequencer and chain of task cells.
`timescale 1ns / 1ps

// Requests are taken when start is high and busy is low. Create, set interval,
// set active and stamp complete at the accepting edge and leave busy low, so
// one of them can be issued every cycle while no scan runs. A scan holds busy
// while a token walks the chain of task cells, one cell per cycle, and a
// final flush state emits the fire held back for the last-in-scan flag. Each fired
// task appears on out_item for exactly one cycle with out_strobe high, in
// index order, at most one per cycle; the receiver cannot stall it and must
// take it as it comes. The last fire of a scan may appear in the cycle after
// busy falls. No clearing pass runs after reset.
module interval_task_dispatcher #(
  parameter int unsigned TASK_COUNT = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  itd_pkg::itd_in_t  in_item,
  output logic              out_strobe,
  output itd_pkg::itd_out_t out_item
);
  import itd_pkg::*;

  itd_cell_ctl_t           ctl;
  logic                    launch;
  logic                    any_fire;
  logic [TIME_BITS-1:0]    now;
  logic [TIME_BITS-1:0]    scan_time;
  logic [TASK_COUNT-1:0]   tok_vec;
  logic [TASK_COUNT-1:0]   fire_vec;

  itd_ctrl #(
    .TASK_COUNT (TASK_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .any_fire   (any_fire),
    .busy       (busy),
    .launch     (launch),
    .ctl        (ctl),
    .now        (now),
    .scan_time  (scan_time),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Only the cell holding the token can fire
  assign any_fire = |fire_vec;

  // Chain of task cells, token enters at cell zero
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = launch;
    end else begin : g_link
      assign tok_in = tok_vec[i-1];
    end

    itd_cell #(
      .CELL_IDX  (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .now       (now),
      .scan_time (scan_time),
      .tok_in    (tok_in),
      .tok_out   (tok_vec[i]),
      .fire      (fire_vec[i])
    );
  end

endmodule

[design/itd_checker.sv]
// Port-level checker for the interval task dispatcher, bound to the top level.
`timescale 1ns / 1ps

`include "interval_task_dispatcher_assert.svh"

module itd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input itd_pkg::itd_in_t  in_item,
  input logic              out_strobe,
  input itd_pkg::itd_out_t out_item
);
  import itd_pkg::*;

  logic req_taken;
  logic scan_req;

  // Request taken this cycle, and whether it is a scan
  assign req_taken = start && !busy;
  assign scan_req  = (in_item.action == ACT_SCAN);

  // A scan request must occupy the block
  `ITD_ASSERT_NEXT(a_scan_busy, req_taken && scan_req, busy, "scan did not raise busy")

  // Table updates finish at once
  `ITD_ASSERT_NEXT(a_update_idle, req_taken && !scan_req, !busy, "non-scan request raised busy")

  // Results only follow a busy cycle
  `ITD_ASSERT_NOW(a_strobe_after_busy, out_strobe, $past(busy), "result without scan in progress")

  // The flagged fire closes the scan, others arrive while it runs
  `ITD_ASSERT_NOW(a_last_closes, out_strobe, out_item.last_in_scan == !busy, "last flag misplaced")

endmodule

bind interval_task_dispatcher itd_checker u_itd_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench of the interval task dispatcher: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
  import itd_pkg::*;

  localparam int unsigned TASKS       = TASK_SLOTS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = TASKS + 4;
  localparam int unsigned RAND_PER_PHASE = 65;

  // Action codes that the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct {
    itd_in_t               req;
    bit                    typed;
    int                    n_fire;
    logic [TASK_IDX_W-1:0] fire_a;
    logic [TASK_IDX_W-1:0] fire_b;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  itd_in_t  in_item;
  logic     out_strobe;
  itd_out_t out_item;

  // Private copy of the task table
  bit [IVAL_W-1:0]  ival_tab  [TASKS];
  bit [CTIME_W-1:0] fired_at  [TASKS];
  bit               enabled   [TASKS];
  bit               present   [TASKS];

  itd_out_t  scan_fires [$];
  itd_out_t  pending_fires [$];
  stim_row_t stim_rows [$];

  bit [CTIME_W-1:0] now_tick;
  int unsigned      idle_pct;
  int unsigned      mismatch_cnt;
  int unsigned      cycle_cnt;

  interval_task_dispatcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Update the table copy for one request; a scan leaves its fires in scan_fires
  task automatic dispatch_request(input itd_in_t req);
    scan_fires.delete();
    case (req.action)
      ACT_CREATE: begin
        ival_tab[req.task_index] = req.interval;
        enabled[req.task_index]  = req.active;
        present[req.task_index]  = req.has_handler;
      end
      ACT_SET_IVAL: ival_tab[req.task_index] = req.interval;
      ACT_SET_ACT:  enabled[req.task_index] = req.active;
      ACT_STAMP: begin
        for (int i = 0; i < TASKS; i++) fired_at[i] = req.current_time;
      end
      ACT_SCAN: begin
        for (int i = 0; i < TASKS; i++) begin
          if (enabled[i] && present[i] &&
              (req.current_time - fired_at[i]) >= ival_tab[i]) begin
            fired_at[i] = req.current_time;
            scan_fires.push_back('{fired_task: TASK_IDX_W'(i), last_in_scan: 1'b0});
          end
        end
        if (scan_fires.size() > 0)
          scan_fires[scan_fires.size() - 1].last_in_scan = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [ACTION_W-1:0] code, input logic [TASK_IDX_W-1:0] idx,
                         input logic [IVAL_W-1:0] ival, input bit hnd, input bit act,
                         input logic [CTIME_W-1:0] tick, input bit typed, input int n_fire,
                         input logic [TASK_IDX_W-1:0] fire_a, input logic [TASK_IDX_W-1:0] fire_b);
    stim_row_t row;
    row.req.action       = code;
    row.req.task_index   = idx;
    row.req.interval     = ival;
    row.req.has_handler  = hnd;
    row.req.active       = act;
    row.req.current_time = tick;
    row.typed  = typed;
    row.n_fire = n_fire;
    row.fire_a = fire_a;
    row.fire_b = fire_b;
    stim_rows.push_back(row);
  endtask

  // At random, hold start low with junk on the request bus
  task automatic maybe_pause();
    logic [95:0] junk;
    if ($urandom_range(99) < idle_pct) begin
      junk = {$urandom, $urandom, $urandom};
      start   <= 1'b0;
      in_item <= itd_in_t'(junk[$bits(itd_in_t)-1:0]);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Present a request and wait for the edge that accepts it
  task automatic send_request(input itd_in_t req);
    in_item <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    dispatch_request(req);
  endtask

  function automatic logic [IVAL_W-1:0] pick_interval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return IVAL_W'($urandom_range(0, 60));
    if (r < 75) return '0;
    if (r < 85) return '1 - IVAL_W'($urandom_range(0, 3));
    return IVAL_W'($urandom);
  endfunction

  // Random request, weighted towards create and scan so that tasks do fire
  task automatic make_request(output itd_in_t req);
    logic [95:0] junk;
    int unsigned r;
    junk = {$urandom, $urandom, $urandom};
    req  = itd_in_t'(junk[$bits(itd_in_t)-1:0]);
    r    = $urandom_range(99);
    if (r < 94) begin
      if ($urandom_range(19) == 0) now_tick = CTIME_W'($urandom);
      else now_tick = now_tick + CTIME_W'($urandom_range(0, 40));
      req.current_time = now_tick;
    end
    if (r < 18) begin
      req.action      = ACT_CREATE;
      req.interval    = pick_interval();
      req.has_handler = ($urandom_range(7) != 0);
      req.active      = ($urandom_range(5) != 0);
    end else if (r < 30) begin
      req.action   = ACT_SET_IVAL;
      req.interval = pick_interval();
    end else if (r < 42) begin
      req.action = ACT_SET_ACT;
    end else if (r < 50) begin
      req.action = ACT_STAMP;
    end else if (r < 94) begin
      req.action = ACT_SCAN;
    end else begin
      req.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end
  endtask

  // Check each fire against the oldest one predicted
  always @(posedge clk) begin
    itd_out_t want;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (pending_fires.size() == 0) begin
        $display("%0t: unexpected fire: expected none, actual task %0d last %b",
                 $realtime, out_item.fired_task, out_item.last_in_scan);
        mismatch_cnt++;
      end else begin
        want = pending_fires.pop_front();
        if (out_strobe !== 1'b1 || out_item.fired_task !== want.fired_task) begin
          $display("%0t: fired_task mismatch: expected %0d, actual %0d (strobe %b)",
                   $realtime, want.fired_task, out_item.fired_task, out_strobe);
          mismatch_cnt++;
        end
        if (out_item.last_in_scan !== want.last_in_scan) begin
          $display("%0t: last_in_scan mismatch: expected %b, actual %b",
                   $realtime, want.last_in_scan, out_item.last_in_scan);
          mismatch_cnt++;
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d fires outstanding",
               $realtime, pending_fires.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    itd_in_t req;
    int unsigned phase_idle [3];
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    idle_pct     = 0;
    phase_idle   = '{0, 59, 20};

    // Directed table: scans on an empty table, time extremes and wrap, absent
    // and disabled tasks, updates to absent entries, stamping, spare codes
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'd0,          1, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'hFFFF_FFFF, 1, 0, 4'd0, 4'd0);
    add_row(ACT_CREATE,   4'd0,  32'd0,          1, 1, 32'd0,          1, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'd0,          1, 1, 4'd0, 4'd0);
    add_row(ACT_CREATE,   4'd15, 32'hFFFF_FFFF, 1, 1, 32'd0,          1, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'hFFFF_FFFF, 1, 2, 4'd0, 4'd15);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'd0,          1, 1, 4'd0, 4'd0);
    add_row(ACT_CREATE,   4'd5,  32'd10,         0, 1, 32'd0,          1, 0, 4'd0, 4'd0);
    add_row(ACT_CREATE,   4'd6,  32'd10,         1, 0, 32'd0,          1, 0, 4'd0, 4'd0);
    add_row(ACT_SET_IVAL, 4'd0,  32'd100,        0, 0, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_SET_IVAL, 4'd9,  32'd3,          0, 0, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_SET_ACT,  4'd6,  32'd0,          0, 1, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_STAMP,    4'd0,  32'd0,          0, 0, 32'h8000_0000, 0, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'h8000_0009, 0, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'h8000_000A, 0, 0, 4'd0, 4'd0);
    add_row(ACT_SET_ACT,  4'd6,  32'd0,          0, 0, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'h8000_0064, 0, 0, 4'd0, 4'd0);
    add_row(ACT_SPARE_FIRST, 4'd15, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1, 0, 4'd0, 4'd0);
    add_row(ACT_SPARE_LAST,  4'd0,  32'd0,        1, 1, 32'd0,          1, 0, 4'd0, 4'd0);
    add_row(ACT_CREATE,   4'd1,  32'd0,          1, 1, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_STAMP,    4'd0,  32'd0,          0, 0, 32'h7FFF_FFFF, 0, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'h7FFF_FFFE, 0, 0, 4'd0, 4'd0);
    add_row(ACT_CREATE,   4'd0,  32'd5,          1, 0, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_SET_IVAL, 4'd15, 32'd0,          0, 0, 32'd0,          0, 0, 4'd0, 4'd0);
    add_row(ACT_SCAN,     4'd0,  32'd0,          0, 0, 32'h7FFF_FFFE, 0, 0, 4'd0, 4'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; typed rows carry their own expected fires
    foreach (stim_rows[k]) begin
      send_request(stim_rows[k].req);
      if (stim_rows[k].typed) begin
        for (int j = 0; j < stim_rows[k].n_fire; j++)
          pending_fires.push_back('{fired_task: (j == 0) ? stim_rows[k].fire_a
                                                         : stim_rows[k].fire_b,
                                    last_in_scan: (j == stim_rows[k].n_fire - 1)});
      end else begin
        foreach (scan_fires[j]) pending_fires.push_back(scan_fires[j]);
      end
    end

    // Random phases with differing sender gaps
    now_tick = 32'h7FFF_FFFE;
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        maybe_pause();
        make_request(req);
        send_request(req);
        foreach (scan_fires[j]) pending_fires.push_back(scan_fires[j]);
      end
    end
    start <= 1'b0;

    // Drain outstanding fires, then watch for strays
    while (pending_fires.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && pending_fires.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
